[design/dltq_pkg.sv]
// Shared types and constants for the delta list timer queue.
`default_nettype none
package dltq_pkg;
  localparam int MAX_TASKS = 16;
  localparam int ID_BITS = 8;
  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int DELTA_W = 34;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_DEL = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;
  localparam logic [1:0] KIND_DISP = 2'd3;

  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_FIRED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_NOT_DUE = 3'd4;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS = 2'd1;
  localparam logic [1:0] OP_REM = 2'd2;
  localparam logic [1:0] OP_ADJ = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] task_handle;
    logic [31:0] start_delay;
    logic [31:0] repeat_period;
    logic [7:0] target_id;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] result_id;
    logic [7:0] result_handle;
  } out_t;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [31:0] period;
    logic [7:0] handle;
    logic [ID_BITS-1:0] ident;
  } entry_t;

  typedef struct packed {
    logic [1:0] op;
    logic [IDX_W-1:0] pos;
    logic [DELTA_W-1:0] addend;
    entry_t fresh;
  } ctl_t;
endpackage
`default_nettype wire

[design/dltq_cell.sv]
// One list entry; loads from its neighbors on insert and remove, and adds to its delta on adjust.
`default_nettype none
module dltq_cell (
  input  logic                  clk,
  input  logic [dltq_pkg::IDX_W-1:0] idx,
  input  dltq_pkg::ctl_t        ctl,
  input  dltq_pkg::entry_t      left,
  input  dltq_pkg::entry_t      right,
  output dltq_pkg::entry_t      q
);
  import dltq_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_INS: begin
        if (idx == ctl.pos) begin
          q <= ctl.fresh;
        end else if (idx > ctl.pos) begin
          q <= left;
        end
      end
      OP_REM: begin
        if (idx >= ctl.pos) begin
          q <= right;
        end
      end
      OP_ADJ: begin
        if (idx == ctl.pos) begin
          q.delta <= q.delta + ctl.addend;
        end
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

[design/delta_list_task_timer_queue.sv]
// Top level: delta list timer queue built from a row of entry cells.
//   channel   direction  handshake          payload
//   command   in         start, busy        item
//   result    out        done (one cycle)   result
//   config    in         cfg_we             cfg_data
// Tick, full add and nothing-due dispatch answer in the cycle after start.
// Add and reinsertion walk the list one entry a cycle, then insert and fix the next delta.
// Delete searches one entry a cycle, then adds the removed delta to the next entry.
// Reset clears count and id counter and sets the step register to 10; entries need no clear.
// Results cannot be stalled; busy holds new commands off until the answer is out.
`default_nettype none
module delta_list_task_timer_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  dltq_pkg::in_t    item,
  output logic             done,
  output dltq_pkg::out_t   result,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_data
);
  import dltq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_INS = 3'd2;
  localparam logic [2:0] S_FIX = 3'd3;
  localparam logic [2:0] S_SRCH = 3'd4;
  localparam logic [2:0] S_DFIX = 3'd5;

  logic [2:0] state;
  logic [CNT_W-1:0] cnt;
  logic [ID_BITS-1:0] nid;
  logic [CNT_W-1:0] pos;
  logic [DELTA_W-1:0] d;
  entry_t ins;
  logic [7:0] target;
  logic [15:0] step;
  ctl_t ctl;
  entry_t cells [MAX_TASKS];
  entry_t cur;
  entry_t head;
  logic [CNT_W-1:0] pos_inc;

  assign cur = cells[pos[IDX_W-1:0]];
  assign head = cells[0];
  assign pos_inc = pos + 1'b1;
  assign busy = (state != S_IDLE);

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    entry_t lft;
    entry_t rgt;
    if (g == 0) begin : g_l0
      assign lft = cells[0];
    end else begin : g_ln
      assign lft = cells[g-1];
    end
    if (g == MAX_TASKS - 1) begin : g_rl
      assign rgt = cells[g];
    end else begin : g_rn
      assign rgt = cells[g+1];
    end
    dltq_cell u_cell (
      .clk  (clk),
      .idx  (IDX_W'(g)),
      .ctl  (ctl),
      .left (lft),
      .right(rgt),
      .q    (cells[g])
    );
  end

  always_comb begin
    ctl = '0;
    ctl.fresh = ins;
    ctl.fresh.delta = d;
    unique case (state)
      S_IDLE: begin
        if (start && item.kind == KIND_TICK && cnt != '0) begin
          ctl.op = OP_ADJ;
          ctl.addend = -DELTA_W'(step);
        end else if (start && item.kind == KIND_DISP && cnt != '0
                     && !($signed(head.delta) > 0)) begin
          ctl.op = OP_REM;
        end
      end
      S_INS: begin
        ctl.op = OP_INS;
        ctl.pos = pos[IDX_W-1:0];
      end
      S_FIX: begin
        if (pos_inc < cnt) begin
          ctl.op = OP_ADJ;
          ctl.pos = pos_inc[IDX_W-1:0];
          ctl.addend = -d;
        end
      end
      S_SRCH: begin
        if (pos != cnt && cur.ident == ID_BITS'(target)) begin
          ctl.op = OP_REM;
          ctl.pos = pos[IDX_W-1:0];
        end
      end
      S_DFIX: begin
        if (pos < cnt) begin
          ctl.op = OP_ADJ;
          ctl.pos = pos[IDX_W-1:0];
          ctl.addend = d;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      nid <= '0;
      step <= 16'd10;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        step <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            pos <= '0;
            unique case (item.kind)
              KIND_ADD: begin
                if (cnt == CNT_W'(MAX_TASKS)) begin
                  result <= '{ST_FULL, 8'd0, 8'd0};
                  done <= 1'b1;
                end else begin
                  d <= DELTA_W'(item.start_delay);
                  ins.period <= item.repeat_period;
                  ins.handle <= item.task_handle;
                  ins.ident <= nid;
                  nid <= nid + 1'b1;
                  result <= '{ST_DONE, 8'(nid), 8'd0};
                  state <= S_WALK;
                end
              end
              KIND_DEL: begin
                target <= item.target_id;
                state <= S_SRCH;
              end
              KIND_TICK: begin
                result <= '{ST_DONE, 8'd0, 8'd0};
                done <= 1'b1;
              end
              default: begin
                if (cnt == '0 || $signed(head.delta) > 0) begin
                  result <= '{ST_NOT_DUE, 8'd0, 8'd0};
                  done <= 1'b1;
                end else begin
                  cnt <= cnt - 1'b1;
                  result <= '{ST_FIRED, 8'(head.ident), head.handle};
                  if (head.period != '0) begin
                    d <= DELTA_W'(head.period) - head.delta;
                    ins <= head;
                    state <= S_WALK;
                  end else begin
                    done <= 1'b1;
                  end
                end
              end
            endcase
          end
        end
        S_WALK: begin
          if (pos < cnt && $signed(d) >= $signed(cur.delta)) begin
            d <= d - cur.delta;
            pos <= pos_inc;
          end else begin
            state <= S_INS;
          end
        end
        S_INS: begin
          cnt <= cnt + 1'b1;
          state <= S_FIX;
        end
        S_FIX: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_SRCH: begin
          if (pos == cnt) begin
            result <= '{ST_NOT_FOUND, 8'd0, 8'd0};
            done <= 1'b1;
            state <= S_IDLE;
          end else if (cur.ident == ID_BITS'(target)) begin
            d <= cur.delta;
            cnt <= cnt - 1'b1;
            state <= S_DFIX;
          end else begin
            pos <= pos_inc;
          end
        end
        S_DFIX: begin
          result <= '{ST_DONE, 8'd0, 8'd0};
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

[design/dltq_checker.sv]
// Port-level checks for the delta list timer queue, bound to the top level.
`default_nettype none
module dltq_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input dltq_pkg::out_t result
);
  import dltq_pkg::*;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_reset_quiet: assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !done)
    else $error("result strobe right after reset");

  a_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted transaction left no trace");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_DONE || result.status == ST_FIRED ||
              result.status == ST_FULL || result.status == ST_NOT_FOUND ||
              result.status == ST_NOT_DUE))
    else $error("undefined status code");
endmodule

bind delta_list_task_timer_queue dltq_checker u_dltq_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);
`default_nettype wire
